FILE: rtl/core/sobel_edge_magnitude_core_macros.svh
// Assertion macros for the verification files of the edge core.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// Implication to the next cycle, checked only outside reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("edge core check failed");

// Implication to the next cycle, checked during reset as well.
`define SEM_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("edge core reset check failed");

`endif

FILE: rtl/core/sem_pkg.sv
package sem_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       pad;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_end;
    } out_item_t;

    typedef logic [23:0] pix_t;
    typedef pix_t [2:0][2:0] win_t;

    typedef struct packed {
        win_t win;
        logic frame_end;
    } q_entry_t;

    typedef enum logic {
        FR_IDLE,
        FR_UPD
    } fr_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GRAD,
        BK_SQR,
        BK_SUM,
        BK_ROOT,
        BK_DONE
    } bk_state_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [10:0] FW_RESET = 11'd640;
    localparam logic [12:0] FH_RESET = 13'd480;

    localparam int QUEUE_DEPTH = 2;
    localparam int QW = $clog2(QUEUE_DEPTH);

    localparam int ROOT_STEPS = 8;
    localparam logic [20:0] SAT_LIMIT = 21'd65281;

    localparam int KERN_X [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
    localparam int KERN_Y [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

endpackage

FILE: rtl/core/sem_front.sv
module sem_front import sem_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_full,
    output logic                  q_push,
    output q_entry_t              q_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    fr_state_t      state_reg, state_next;
    logic [10:0]    fw_reg;
    logic [12:0]    fh_reg;
    logic [CW-1:0]  col_reg, cur_c_reg, c0, c_new;
    logic [RW-1:0]  row_reg, cur_r_reg, r0, r_new;
    logic [WW-1:0]  w, c_inc;
    logic [RW-1:0]  h, hp1;
    pix_t           pix_reg, top_reg, mid_reg;
    win_t           win_reg, win_nx, win_mask;
    logic [2:0]     rok, cok;
    logic           acc, emit;

    pix_t upper_mem [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    always_comb begin
        if (fw_reg == '0) begin
            w = WW'(1);
        end else if (int'(fw_reg) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h = RW'(1);
        end else if (int'(fh_reg) > MAX_HEIGHT) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(fh_reg);
        end
        hp1 = h + RW'(1);
    end

    assign s_ready = (state_reg == FR_IDLE) && !q_full;
    assign acc = s_valid && s_ready;

    always_comb begin
        if ((WW'(col_reg) >= w) || (row_reg > hp1)) begin
            c0 = '0;
            r0 = '0;
        end else begin
            c0 = col_reg;
            r0 = row_reg;
        end
        c_inc = WW'(c0) + WW'(1);
        if (r0 == hp1) begin
            c_new = '0;
            r_new = '0;
        end else if (c_inc >= w) begin
            c_new = '0;
            r_new = r0 + RW'(1);
        end else begin
            c_new = CW'(c_inc);
            r_new = r0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= FW_RESET;
            fh_reg  <= FH_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                fw_reg  <= cfg_wdata[10:0];
                col_reg <= '0;
                row_reg <= '0;
            end else if (cfg_index == CFG_FRAME_HEIGHT) begin
                fh_reg  <= cfg_wdata[12:0];
                col_reg <= '0;
                row_reg <= '0;
            end
        end else if (acc) begin
            col_reg <= c_new;
            row_reg <= r_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE: begin
                if (acc) begin
                    state_next = FR_UPD;
                end
            end
            FR_UPD: begin
                state_next = FR_IDLE;
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            pix_reg   <= {s_data.blue_in, s_data.green_in, s_data.red_in};
            cur_c_reg <= c0;
            cur_r_reg <= r0;
            top_reg   <= upper_mem[c0];
            mid_reg   <= middle_mem[c0];
        end
        if (state_reg == FR_UPD) begin
            upper_mem[cur_c_reg]  <= mid_reg;
            middle_mem[cur_c_reg] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (state_reg == FR_UPD) begin
            win_reg <= win_nx;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_nx[i][0] = win_reg[i][1];
            win_nx[i][1] = win_reg[i][2];
        end
        win_nx[0][2] = top_reg;
        win_nx[1][2] = mid_reg;
        win_nx[2][2] = pix_reg;

        rok[1] = 1'b1;
        cok[1] = 1'b1;
        if (cur_c_reg == '0) begin
            cok[0] = (w >= WW'(2));
            cok[2] = 1'b0;
            rok[0] = (cur_r_reg >= RW'(3));
            rok[2] = (cur_r_reg <= h);
        end else begin
            cok[0] = (cur_c_reg >= CW'(2));
            cok[2] = 1'b1;
            rok[0] = (cur_r_reg >= RW'(2));
            rok[2] = (cur_r_reg < h);
        end
        emit = (cur_r_reg >= RW'(2)) || ((cur_r_reg == RW'(1)) && (cur_c_reg != '0));

        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                win_mask[i][j] = (rok[i] && cok[j]) ? win_nx[i][j] : '0;
            end
        end
    end

    assign q_push = (state_reg == FR_UPD) && emit;
    assign q_data.win = win_mask;
    assign q_data.frame_end = (cur_r_reg == hp1);

endmodule

FILE: rtl/core/sem_queue.sv
module sem_queue import sem_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_data
);

    q_entry_t        entry_reg [QUEUE_DEPTH];
    logic [QW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QW:0]     count_reg;

    assign full = (count_reg == (QW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
            end
            if (pop && head_valid) begin
                rd_ptr_reg <= (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
            end
            count_reg <= count_reg + (QW+1)'(push && !full) - (QW+1)'(pop && head_valid);
        end
    end

endmodule

FILE: rtl/core/sem_back.sv
module sem_back import sem_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  q_entry_t  q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    bk_state_t          state_reg, state_next;
    win_t               win_reg;
    logic               fe_reg;
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic signed [10:0] gx_c [3];
    logic signed [10:0] gy_c [3];
    logic [19:0]        sqx_reg [3];
    logic [19:0]        sqy_reg [3];
    logic [20:0]        sum_c [3];
    logic               sat_reg [3];
    logic [15:0]        rad_reg [3];
    logic [9:0]         rem_reg [3];
    logic [9:0]         rem_next [3];
    logic [7:0]         root_reg [3];
    logic [7:0]         root_next [3];
    logic [7:0]         edge_c [3];
    logic [2:0]         step_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign q_pop = (state_reg == BK_IDLE) && q_valid;

    always_comb begin
        int sx, sy, v;
        for (int ch = 0; ch < 3; ch++) begin
            sx = 0;
            sy = 0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v = int'(win_reg[i][j][8*ch +: 8]);
                    sx = sx + KERN_X[i][j] * v;
                    sy = sy + KERN_Y[i][j] * v;
                end
            end
            gx_c[ch] = 11'(sx);
            gy_c[ch] = 11'(sy);
        end
    end

    always_comb begin
        logic [11:0] rem_sh, trial;
        for (int ch = 0; ch < 3; ch++) begin
            sum_c[ch] = 21'(sqx_reg[ch]) + 21'(sqy_reg[ch]);
            rem_sh = {rem_reg[ch], rad_reg[ch][15:14]};
            trial = {2'b00, root_reg[ch], 2'b01};
            if (rem_sh >= trial) begin
                rem_next[ch] = 10'(rem_sh - trial);
                root_next[ch] = {root_reg[ch][6:0], 1'b1};
            end else begin
                rem_next[ch] = rem_sh[9:0];
                root_next[ch] = {root_reg[ch][6:0], 1'b0};
            end
            if (sat_reg[ch]) begin
                edge_c[ch] = 8'd255;
            end else if (rem_reg[ch] > {2'b00, root_reg[ch]}) begin
                edge_c[ch] = root_reg[ch] + 8'd1;
            end else begin
                edge_c[ch] = root_reg[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_GRAD;
                end
            end
            BK_GRAD: begin
                state_next = BK_SQR;
            end
            BK_SQR: begin
                state_next = BK_SUM;
            end
            BK_SUM: begin
                state_next = BK_ROOT;
            end
            BK_ROOT: begin
                if (step_reg == 3'(ROOT_STEPS - 1)) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    win_reg <= q_head.win;
                    fe_reg  <= q_head.frame_end;
                end
            end
            BK_GRAD: begin
                for (int ch = 0; ch < 3; ch++) begin
                    gx_reg[ch] <= gx_c[ch];
                    gy_reg[ch] <= gy_c[ch];
                end
            end
            BK_SQR: begin
                for (int ch = 0; ch < 3; ch++) begin
                    sqx_reg[ch] <= 20'(gx_reg[ch] * gx_reg[ch]);
                    sqy_reg[ch] <= 20'(gy_reg[ch] * gy_reg[ch]);
                end
            end
            BK_SUM: begin
                for (int ch = 0; ch < 3; ch++) begin
                    sat_reg[ch]  <= (sum_c[ch] >= SAT_LIMIT);
                    rad_reg[ch]  <= sum_c[ch][15:0];
                    rem_reg[ch]  <= '0;
                    root_reg[ch] <= '0;
                end
                step_reg <= '0;
            end
            BK_ROOT: begin
                for (int ch = 0; ch < 3; ch++) begin
                    rem_reg[ch]  <= rem_next[ch];
                    root_reg[ch] <= root_next[ch];
                    rad_reg[ch]  <= {rad_reg[ch][13:0], 2'b00};
                end
                step_reg <= step_reg + 3'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == BK_DONE) && !m_valid_reg) begin
            m_data_reg.red_edge   <= edge_c[0];
            m_data_reg.green_edge <= edge_c[1];
            m_data_reg.blue_edge  <= edge_c[2];
            m_data_reg.frame_end  <= fe_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == BK_DONE) && !m_valid_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/sobel_edge_magnitude_core.sv
// Streaming 3x3 Sobel edge magnitude for RGB pixels. Send a frame in raster order followed by
// frame_width+1 pad requests; each request from number frame_width+1 on returns one result
// whose channels are the rounded, 255-clamped Sobel magnitude, with frame_end on the last pixel.
// The front end takes a pixel while the queue is not full (registered line-store read, then
// write-back before the next pixel) and pushes the masked window into a two-entry queue. The
// back end handles one result at a time (pop, gradient, square, sum, eight square-root digit
// steps, output load once the last result is taken); root iteration sets the sustained rate.
// Line stores need no clearing after reset. Writing a frame register restarts the frame position.
module sobel_edge_magnitude_core import sem_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic     q_full, q_push, q_pop, q_valid;
    q_entry_t q_in, q_head;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    sem_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    sem_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/core/sem_checker.sv
`include "sobel_edge_magnitude_core_macros.svh"

module sem_checker import sem_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `SEM_ASSERT_NEXT_ALWAYS(a_reset_idle, !aresetn, !m_valid)
    `SEM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `SEM_ASSERT_NEXT(a_in_gap, s_valid && s_ready, !s_ready)
    `SEM_ASSERT_NEXT(a_out_gap, m_valid && m_ready, !m_valid)

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
